// ----- sv/pst_pkg.sv -----
// Shared types and constants for the per-source request throttle.
`timescale 1ns / 1ps

package pst_pkg;

    // Default table depth and reset value of the hold time.
    localparam int unsigned TABLE_ENTRIES_DEF = 16;
    localparam logic [15:0] HOLD_RESET        = 16'd5;

    // Verdict codes carried on the result channel.
    localparam logic [1:0] VERDICT_NEW       = 2'd0;
    localparam logic [1:0] VERDICT_KNOWN     = 2'd1;
    localparam logic [1:0] VERDICT_THROTTLED = 2'd2;
    localparam logic [1:0] VERDICT_FULL      = 2'd3;

    // One table entry as it sits in the entry memory.
    typedef struct packed {
        logic        valid;
        logic [31:0] address;
        logic [31:0] last_time;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear_wr;
        logic idx_clr;
        logic idx_inc;
        logic walk_rd;
        logic finish;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;
        logic out_free;
    } status_t;

endpackage

// ----- sv/pst_req_if.sv -----
// Request channel: source address and current time.
`timescale 1ns / 1ps

interface pst_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] source_address;
    logic [31:0] now_seconds;

    modport source (output valid, output source_address, output now_seconds, input ready);
    modport sink (input valid, input source_address, input now_seconds, output ready);
endinterface

// ----- sv/pst_rsp_if.sv -----
// Result channel: the verdict for one request.
`timescale 1ns / 1ps

interface pst_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] verdict;

    modport source (output valid, output verdict, input ready);
    modport sink (input valid, input verdict, output ready);
endinterface

// ----- sv/pst_ctrl.sv -----
// Controller state machine that sequences the table walk for each request.
`timescale 1ns / 1ps

module pst_ctrl
    import pst_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_WALK   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_INSERT = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register; reset starts the clearing pass over the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk_rd = 1'b1;
                if (status.idx_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_DRAIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// ----- sv/pst_dp.sv -----
// Datapath: entry memory, walk counter, age check, verdict and output register.
`timescale 1ns / 1ps

module pst_dp
    import pst_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    input  logic [31:0] in_address,
    input  logic [31:0] in_now,
    input  cmd_t        cmd,
    output status_t     status,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_verdict
);

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    logic [15:0]      hold_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] ev_idx_reg;
    logic             ev_pend_reg;
    logic [31:0]      addr_reg;
    logic [31:0]      now_reg;
    logic             hit_found_reg;
    logic [1:0]       hit_verdict_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [1:0]       verdict_reg;
    logic             out_valid_reg;
    logic [1:0]       out_verdict_reg;

    logic [31:0]      age;
    logic             stale;
    logic             keep;
    logic             hit;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    entry_t           mem_wd;

    // Age of the entry under evaluation and its purge and match decisions.
    always_comb
    begin
        age   = now_reg - rd_data_reg.last_time;
        stale = age > {16'd0, hold_reg};
        keep  = rd_data_reg.valid && !stale;
        hit   = keep && (rd_data_reg.address == addr_reg);
    end

    // Write port select: clearing pass, insertion, or write-back of the walk.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = idx_reg;
        mem_wd = '0;
        if (cmd.clear_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.finish)
        begin
            mem_we = !hit_found_reg && free_found_reg;
            mem_wa = free_idx_reg;
            mem_wd = '{valid: 1'b1, address: addr_reg, last_time: now_reg};
        end
        else if (ev_pend_reg)
        begin
            mem_wa = ev_idx_reg;
            if (rd_data_reg.valid && !keep)
            begin
                mem_we = 1'b1;
                mem_wd = '{valid: 1'b0, address: rd_data_reg.address,
                           last_time: rd_data_reg.last_time};
            end
            else if (hit)
            begin
                mem_we = 1'b1;
                mem_wd = '{valid: 1'b1, address: rd_data_reg.address, last_time: now_reg};
            end
        end
    end

    // Entry memory with one write port and a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[idx_reg];
    end

    // Request payload, captured when the request is taken.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= in_address;
            now_reg  <= in_now;
        end
    end

    // Match and free-slot results gathered during the walk.
    always_ff @(posedge clk)
    begin
        if (ev_pend_reg && hit)
        begin
            hit_verdict_reg <= (age < {16'd0, hold_reg}) ? VERDICT_THROTTLED
                                                         : VERDICT_KNOWN;
        end
        if (ev_pend_reg && !keep && !free_found_reg)
        begin
            free_idx_reg <= ev_idx_reg;
        end
        if (cmd.finish)
        begin
            if (hit_found_reg)
            begin
                verdict_reg <= hit_verdict_reg;
            end
            else if (free_found_reg)
            begin
                verdict_reg <= VERDICT_NEW;
            end
            else
            begin
                verdict_reg <= VERDICT_FULL;
            end
        end
        if (cmd.load_out)
        begin
            out_verdict_reg <= verdict_reg;
        end
    end

    // Control registers: hold time, walk index, flags and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg       <= HOLD_RESET;
            idx_reg        <= '0;
            ev_idx_reg     <= '0;
            ev_pend_reg    <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                hold_reg <= cfg_write_data;
            end
            if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            ev_idx_reg  <= idx_reg;
            ev_pend_reg <= cmd.walk_rd;
            if (cmd.capture)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (ev_pend_reg)
            begin
                if (hit)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (!keep)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status back to the controller and the output channel.
    always_comb
    begin
        status.idx_last = idx_reg == IDX_LAST;
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_verdict = out_verdict_reg;

endmodule

// ----- sv/per_source_request_throttle.sv -----
// Top level of the per-source request throttle.
//
//   Channel  Dir  Handshake     Word contents
//   req      in   valid/ready   source_address[31:0], now_seconds[31:0]
//   rsp      out  valid/ready   verdict[1:0]
//   cfg      in   write enable  hold_seconds[15:0]
//
// The verdict word is offered after the one-entry-per-cycle walk over the entry memory, a
// drain step for its registered read port and the insert step; a new request is taken only
// once the previous verdict word has been loaded into the output register.
// After reset a clearing pass over the table frees every entry with req.ready low.
// hold_seconds resets to 5. A stalled rsp holds the block only once the next verdict is
// done, since the waiting word sits in an output register.
`timescale 1ns / 1ps

module per_source_request_throttle
    import pst_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [15:0] cfg_write_data,
    pst_req_if.sink     req,
    pst_rsp_if.source   rsp
);

    cmd_t    cmd;
    status_t status;

    // Sequencing of the walk for each request.
    pst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table storage, age checks and the result register.
    pst_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_address     (req.source_address),
        .in_now         (req.now_seconds),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_verdict    (rsp.verdict)
    );

endmodule

// ----- sv/pst_chk.sv -----
// Port-level checker for the per-source request throttle, bound to the top level.
`timescale 1ns / 1ps

module pst_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [1:0] rsp_verdict
);

    logic       req_acc;
    logic       rsp_acc;
    logic [1:0] pend_reg;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // Requests taken whose verdict word has not yet been delivered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, req_acc} - {1'b0, rsp_acc};
        end
    end

    // A verdict word is only delivered for a request that was taken.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc |-> pend_reg != 2'd0)
        else $error("verdict delivered with no request outstanding");

    // At most one request in work plus one verdict waiting.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 2'd2)
        else $error("more than two requests outstanding");

    // The block works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("request taken while the previous one is in work");

    // A stalled verdict word stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("verdict withdrawn while stalled");

    // A stalled verdict word keeps its value.
    a_verdict_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_verdict))
        else $error("verdict changed while stalled");

endmodule

bind per_source_request_throttle pst_chk u_pst_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_verdict (rsp.verdict)
);

// ----- tb/testbench.sv -----
// Self-checking testbench for the per-source request throttle.
`timescale 1ns / 1ps

module testbench;
    import pst_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int POOL_SIZE   = 20;
    localparam int PHASE_ITEMS = 190;

    // Shadow copy of the source table that predicts each verdict word and
    // matches the returned words in order.
    class verdict_book;
        logic [15:0] hold;
        bit          live  [TABLE_ENTRIES_DEF];
        logic [31:0] owner [TABLE_ENTRIES_DEF];
        logic [31:0] stamp [TABLE_ENTRIES_DEF];
        logic [1:0]  expected[$];
        int          errors;

        function new();
            hold   = HOLD_RESET;
            errors = 0;
            foreach (live[i])
            begin
                live[i]  = 1'b0;
                owner[i] = '0;
                stamp[i] = '0;
            end
        endfunction

        function void set_hold(logic [15:0] value);
            hold = value;
        endfunction

        function int pending();
            return expected.size();
        endfunction

        // Purge stale sources, then look up, refresh or insert the requester.
        function void note_request(logic [31:0] src, logic [31:0] now);
            logic [31:0] age;
            logic [1:0]  verdict;
            int          free_slot;
            bit          found;
            free_slot = -1;
            found     = 1'b0;
            verdict   = VERDICT_FULL;
            for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
            begin
                age = now - stamp[i];
                if (live[i] && age > {16'd0, hold})
                    live[i] = 1'b0;
            end
            for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
            begin
                if (!live[i])
                begin
                    if (free_slot < 0)
                        free_slot = i;
                end
                else if (!found && owner[i] == src)
                begin
                    age      = now - stamp[i];
                    stamp[i] = now;
                    verdict  = (age < {16'd0, hold}) ? VERDICT_THROTTLED : VERDICT_KNOWN;
                    found    = 1'b1;
                end
            end
            // An unknown source takes the lowest free entry, if any is left.
            if (!found && free_slot >= 0)
            begin
                live[free_slot]  = 1'b1;
                owner[free_slot] = src;
                stamp[free_slot] = now;
                verdict          = VERDICT_NEW;
            end
            expected.push_back(verdict);
        endfunction

        function void check_verdict(logic [1:0] seen);
            logic [1:0] want;
            if (expected.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("verdict word %0d arrived with no request outstanding", seen);
            end
            else
            begin
                want = expected.pop_front();
                if (seen !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("verdict mismatch: expected %0d, got %0d", want, seen);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [15:0] cfg_write_data;
    int          burst_left;
    int          cycle_count;

    verdict_book book = new();

    pst_req_if req_ch();
    pst_rsp_if rsp_ch();

    per_source_request_throttle DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req_ch),
        .rsp            (rsp_ch)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[per_source_request_throttle] ERROR");
        $finish;
    end

    // Result side: check every accepted verdict word, then pick the next
    // ready level from a stall pattern that changes mode now and then.
    initial
    begin
        int seg_left;
        int mode;
        int run_left;
        bit level;
        seg_left = 0;
        mode     = 0;
        run_left = 0;
        level    = 1'b1;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                book.check_verdict(rsp_ch.verdict);
            if (seg_left == 0)
            begin
                mode     = $urandom_range(0, 2);
                seg_left = $urandom_range(40, 300);
            end
            seg_left--;
            case (mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    if (run_left == 0)
                    begin
                        level    = !level;
                        run_left = level ? $urandom_range(1, 12) : $urandom_range(1, 30);
                    end
                    run_left--;
                    rsp_ch.ready <= level;
                end
            endcase
        end
    end

    // Decide after each accepted word whether the burst goes on or a gap follows.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Offer one request word and hold it until the block takes it.
    task automatic send_request(input logic [31:0] src, input logic [31:0] now);
        req_ch.valid          <= 1'b1;
        req_ch.source_address <= src;
        req_ch.now_seconds    <= now;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        book.note_request(src, now);
        pace_sender();
    endtask

    // Stop sending and wait for every outstanding verdict word.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // The hold time only changes while nothing is in flight.
    task automatic write_hold(input logic [15:0] value);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        book.set_hold(value);
    endtask

    // Random traffic from a small pool of sources so that the table fills,
    // entries age out near the hold boundary, and time sometimes steps back.
    task automatic run_phase(input logic [15:0] hold, input int count);
        logic [31:0] pool[POOL_SIZE];
        logic [31:0] now;
        logic [31:0] src;
        int          pick;
        write_hold(hold);
        foreach (pool[i])
            pool[i] = $urandom();
        now = $urandom();
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                now = now + $urandom_range(0, 3);
            else if (pick < 85)
                now = now + 32'(hold) + $urandom_range(0, 2) - 32'd1;
            else if (pick < 92)
                now = now - $urandom_range(1, 8);
            else
                now = $urandom();
            src = ($urandom_range(0, 9) == 0) ? $urandom() : pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(src, now);
        end
    endtask

    initial
    begin
        logic [15:0] phase_holds[8];
        rst_n                 <= 1'b0;
        cfg_write_en          <= 1'b0;
        cfg_write_data        <= '0;
        req_ch.valid          <= 1'b0;
        req_ch.source_address <= '0;
        req_ch.now_seconds    <= '0;
        burst_left             = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Address and time extremes, then an age equal to the hold and time running backwards,
        // all at the reset hold of five seconds.
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h0000_0000, 32'd2);
        send_request(32'h0000_0000, 32'd7);
        send_request(32'h0000_0000, 32'd6);

        // Fill every entry, overflow it, then age the table out.
        for (int i = 0; i < TABLE_ENTRIES_DEF; i++)
            send_request(32'h8A5A_0000 | i, 32'd100);
        send_request(32'h7FFF_FFFF, 32'd100);
        send_request(32'h8A5A_0000, 32'd101);
        send_request(32'h7FFF_FFFF, 32'd106);

        // With no hold time only an age of zero keeps an entry.
        write_hold(16'd0);
        send_request(32'h1234_5678, 32'd50);
        send_request(32'h1234_5678, 32'd50);
        send_request(32'h1234_5678, 32'd51);

        phase_holds = '{16'd0, 16'd1, 16'hFFFF, 16'd3, 16'd5, 16'd0, 16'd12, 16'd2};
        phase_holds[5] = 16'($urandom_range(0, 65535));
        foreach (phase_holds[p])
            run_phase(phase_holds[p], PHASE_ITEMS);

        drain();
        repeat (TABLE_ENTRIES_DEF + 8) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("[per_source_request_throttle] OK");
        else
            $display("[per_source_request_throttle] ERROR");
        $finish;
    end

endmodule
